>>> src/clbn_pkg.sv
`timescale 1ns / 1ps
package clbn_pkg;

  localparam int POS_W      = 32;
  localparam int CNT_W      = 7;
  localparam int COORD_W    = 6;
  localparam int IDX_W      = 18;
  localparam int ACC_W      = 64;
  localparam int MAC_A_W    = POS_W + 1;
  localparam int MAC_B_W    = POS_W / 2;
  localparam int DIGIT_W    = 4;
  localparam int REG_ADDR_W = 5;
  localparam int REG_IDX_W  = REG_ADDR_W - 2;
  localparam int APB_DATA_W = 32;

  localparam logic [REG_IDX_W-1:0] REG_CELLS_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_Z_PER   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INV_X   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INV_Y   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_INV_Z   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_Z_REF   = 3'd7;

  localparam logic OP_BIN = 1'b0;
  localparam logic OP_NBR = 1'b1;

  localparam logic [CNT_W-1:0] CELLS_RST = 7'd1;
  localparam logic [POS_W-1:0] INV_RST   = 32'h0001_0000;

  typedef struct packed {
    logic [CNT_W-1:0]        cells_x;
    logic [CNT_W-1:0]        cells_y;
    logic [CNT_W-1:0]        cells_z;
    logic                    z_periodic;
    logic [POS_W-1:0]        inv_x;
    logic [POS_W-1:0]        inv_y;
    logic [POS_W-1:0]        inv_z;
    logic signed [POS_W-1:0] z_ref;
  } cfg_regs_t;

  typedef struct packed {
    logic               en;
    logic               sh;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic [ACC_W-1:0]   addend;
  } mac_cmd_t;

endpackage

>>> src/clbn_regs.sv
`timescale 1ns / 1ps
module clbn_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [clbn_pkg::REG_ADDR_W-1:0]     paddr,
  input  logic [clbn_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [clbn_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output clbn_pkg::cfg_regs_t                 cfg
);
  import clbn_pkg::*;

  cfg_regs_t              cfg_r;
  cfg_regs_t              cfg_nxt;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   wr_en;

  assign reg_idx = paddr[REG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_CELLS_X: cfg_nxt.cells_x    = pwdata[CNT_W-1:0];
        REG_CELLS_Y: cfg_nxt.cells_y    = pwdata[CNT_W-1:0];
        REG_CELLS_Z: cfg_nxt.cells_z    = pwdata[CNT_W-1:0];
        REG_Z_PER:   cfg_nxt.z_periodic = pwdata[0];
        REG_INV_X:   cfg_nxt.inv_x      = pwdata[POS_W-1:0];
        REG_INV_Y:   cfg_nxt.inv_y      = pwdata[POS_W-1:0];
        REG_INV_Z:   cfg_nxt.inv_z      = pwdata[POS_W-1:0];
        REG_Z_REF:   cfg_nxt.z_ref      = pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CELLS_X: prdata = APB_DATA_W'(cfg_r.cells_x);
      REG_CELLS_Y: prdata = APB_DATA_W'(cfg_r.cells_y);
      REG_CELLS_Z: prdata = APB_DATA_W'(cfg_r.cells_z);
      REG_Z_PER:   prdata = APB_DATA_W'(cfg_r.z_periodic);
      REG_INV_X:   prdata = APB_DATA_W'(cfg_r.inv_x);
      REG_INV_Y:   prdata = APB_DATA_W'(cfg_r.inv_y);
      REG_INV_Z:   prdata = APB_DATA_W'(cfg_r.inv_z);
      REG_Z_REF:   prdata = APB_DATA_W'(unsigned'(cfg_r.z_ref));
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cells_x    <= CELLS_RST;
      cfg_r.cells_y    <= CELLS_RST;
      cfg_r.cells_z    <= CELLS_RST;
      cfg_r.z_periodic <= 1'b1;
      cfg_r.inv_x      <= INV_RST;
      cfg_r.inv_y      <= INV_RST;
      cfg_r.inv_z      <= INV_RST;
      cfg_r.z_ref      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> src/clbn_mac.sv
`timescale 1ns / 1ps
module clbn_mac (
  input  logic                          clk,
  input  clbn_pkg::mac_cmd_t            cmd,
  output logic [clbn_pkg::ACC_W-1:0]    res
);
  import clbn_pkg::*;

  localparam int PROD_W = MAC_A_W + MAC_B_W;

  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  prod_ext;
  logic [ACC_W-1:0]  res_r;
  logic [ACC_W-1:0]  res_nxt;

  assign prod     = PROD_W'(cmd.a) * PROD_W'(cmd.b);
  assign prod_ext = ACC_W'(prod);
  assign res      = res_r;

  always_comb begin
    res_nxt = res_r;
    if (cmd.en) begin
      res_nxt = cmd.addend + (cmd.sh ? (prod_ext << MAC_B_W) : prod_ext);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

>>> src/clbn_rem.sv
`timescale 1ns / 1ps
module clbn_rem #(
  parameter int CW  = 7,
  parameter int DVW = 32,
  parameter int STW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [CW-1:0]  divisor,
  input  logic [STW-1:0] steps,
  output logic           busy,
  output logic [CW-1:0]  rem
);
  import clbn_pkg::*;

  logic           busy_r, busy_nxt;
  logic [STW-1:0] cnt_r, cnt_nxt;
  logic [DVW-1:0] dvd_r, dvd_nxt;
  logic [CW-1:0]  rem_r, rem_nxt;
  logic [CW-1:0]  dsr_r, dsr_nxt;
  logic [CW:0]    part;

  assign busy = busy_r;
  assign rem  = rem_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    part     = '0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      for (int k = 0; k < DIGIT_W; k++) begin
        part = {rem_nxt, dvd_r[DVW-1-k]};
        if (part >= {1'b0, dsr_r}) begin
          part = part - {1'b0, dsr_r};
        end
        rem_nxt = part[CW-1:0];
      end
      dvd_nxt = dvd_r << DIGIT_W;
      cnt_nxt = cnt_r - STW'(1);
      if (cnt_r == STW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

>>> src/cell_list_binning_and_neighbors.sv
`timescale 1ns / 1ps
// Bin word: per axis, the 33x16 multiplier makes two passes, then a fold and the 4-bit-per-cycle
//   remainder unit run; two index passes on the multiplier follow before the word is registered.
// Neighbour words: three short remainder runs and seven multiplier passes come first, then
//   one word per cycle while out_ready is high, 9, 18 or 27 words.
// One item at a time: in_ready rises together with out_valid of the final word.
// Reset (synchronous, active low) clears the sequencer, output valid and config defaults.
module cell_list_binning_and_neighbors #(
  parameter int MAX_AXIS_CELLS = 64,
  parameter int POS_FRAC_BITS  = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_opcode,
  input  logic signed [clbn_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [clbn_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [clbn_pkg::POS_W-1:0]     in_pos_z,
  input  logic [clbn_pkg::COORD_W-1:0]          in_cell_col,
  input  logic [clbn_pkg::COORD_W-1:0]          in_cell_row,
  input  logic [clbn_pkg::COORD_W-1:0]          in_cell_layer,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [clbn_pkg::IDX_W-1:0]            out_cell_index,
  output logic                                  out_out_of_range,
  output logic                                  out_last,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [clbn_pkg::REG_ADDR_W-1:0]       paddr,
  input  logic [clbn_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [clbn_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import clbn_pkg::*;

  localparam int CW        = $clog2(MAX_AXIS_CELLS + 1);
  localparam int CRW       = $clog2(MAX_AXIS_CELLS);
  localparam int EW        = (CW > CNT_W) ? CW : CNT_W;
  localparam int FB2       = 2 * POS_FRAC_BITS;
  localparam int QW        = ACC_W - FB2;
  localparam int NSTEPS    = (QW + DIGIT_W - 1) / DIGIT_W;
  localparam int QP        = NSTEPS * DIGIT_W;
  localparam int STW       = $clog2(NSTEPS + 1);
  localparam int NBR_STEPS = (COORD_W + DIGIT_W - 1) / DIGIT_W;
  localparam int NBR_PAD   = NBR_STEPS * DIGIT_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MLO    = 4'd1;
  localparam logic [3:0] S_MHI    = 4'd2;
  localparam logic [3:0] S_FOLD   = 4'd3;
  localparam logic [3:0] S_RWAIT  = 4'd4;
  localparam logic [3:0] S_IDX1   = 4'd5;
  localparam logic [3:0] S_IDX2   = 4'd6;
  localparam logic [3:0] S_NSTART = 4'd7;
  localparam logic [3:0] S_OFF    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] LAST_TAP = 2'd2;
  localparam logic [2:0] OFF_LAST = 3'd7;

  function automatic logic [CW-1:0] clamp_count(input logic [CNT_W-1:0] c);
    logic [EW-1:0] e;
    e = EW'(c);
    if (e == '0) return CW'(1);
    if (e > EW'(MAX_AXIS_CELLS)) return CW'(MAX_AXIS_CELLS);
    return CW'(e);
  endfunction

  function automatic logic [MAC_A_W-1:0] mag33(input logic [MAC_A_W-1:0] v);
    return v[MAC_A_W-1] ? (~v + MAC_A_W'(1)) : v;
  endfunction

  function automatic logic [CRW-1:0] wrap_inc(input logic [CRW-1:0] c, input logic [CW-1:0] n);
    logic [CW-1:0] s;
    s = CW'(c) + CW'(1);
    return (s == n) ? CRW'(0) : CRW'(s);
  endfunction

  function automatic logic [CRW-1:0] wrap_dec(input logic [CRW-1:0] c, input logic [CW-1:0] n);
    return (c == '0) ? CRW'(n - CW'(1)) : (c - CRW'(1));
  endfunction

  cfg_regs_t          cfg;
  logic [CW-1:0]      nx, ny, nz;

  mac_cmd_t           mac_cmd;
  logic [ACC_W-1:0]   mac_res;

  logic               rem_start;
  logic [QP-1:0]      rem_dividend;
  logic [CW-1:0]      rem_divisor;
  logic [STW-1:0]     rem_steps;
  logic               rem_busy;
  logic [CW-1:0]      rem_val;

  logic [3:0]         state_r, state_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic               op_r, op_nxt;
  logic [MAC_A_W-1:0] mag_r [0:2];
  logic [MAC_A_W-1:0] mag_nxt [0:2];
  logic               neg_r [0:2];
  logic               neg_nxt [0:2];
  logic [COORD_W-1:0] ncrd_r [0:2];
  logic [COORD_W-1:0] ncrd_nxt [0:2];
  logic [CRW-1:0]     coord_r [0:2];
  logic [CRW-1:0]     coord_nxt [0:2];
  logic               oor_r, oor_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [1:0]         i_r, i_nxt;
  logic [1:0]         j_r, j_nxt;
  logic [1:0]         p_r, p_nxt;
  logic [IDX_W-1:0]   nxny_r, nxny_nxt;
  logic [IDX_W-1:0]   rowoff_r [0:2];
  logic [IDX_W-1:0]   rowoff_nxt [0:2];
  logic [IDX_W-1:0]   planeoff_r [0:2];
  logic [IDX_W-1:0]   planeoff_nxt [0:2];
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic               out_oor_r, out_oor_nxt;
  logic               out_last_r, out_last_nxt;

  logic [MAC_A_W-1:0] in_vx, in_vy, in_vz;
  logic [CW-1:0]      ax_n;
  logic [POS_W-1:0]   ax_inv;
  logic [ACC_W-1:0]   fold_h, fold_t;
  logic               fold_oor;

  logic [CRW-1:0]     xs [0:2];
  logic [CRW-1:0]     ys [0:2];
  logic [CRW-1:0]     zs [0:2];
  logic               has_m, has_p;
  logic [1:0]         nplanes;
  logic [IDX_W-1:0]   emit_idx;
  logic               emit_last;

  clbn_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clbn_mac u_mac (
    .clk (clk),
    .cmd (mac_cmd),
    .res (mac_res)
  );

  clbn_rem #(
    .CW  (CW),
    .DVW (QP),
    .STW (STW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .steps    (rem_steps),
    .busy     (rem_busy),
    .rem      (rem_val)
  );

  assign nx = clamp_count(cfg.cells_x);
  assign ny = clamp_count(cfg.cells_y);
  assign nz = clamp_count(cfg.cells_z);

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_cell_index   = out_idx_r;
  assign out_out_of_range = out_oor_r;
  assign out_last         = out_last_r;

  assign in_vx = {in_pos_x[POS_W-1], in_pos_x};
  assign in_vy = {in_pos_y[POS_W-1], in_pos_y};
  assign in_vz = {in_pos_z[POS_W-1], in_pos_z} - {cfg.z_ref[POS_W-1], cfg.z_ref};

  always_comb begin
    case (axis_r)
      AXIS_X: begin
        ax_n   = nx;
        ax_inv = cfg.inv_x;
      end
      AXIS_Y: begin
        ax_n   = ny;
        ax_inv = cfg.inv_y;
      end
      default: begin
        ax_n   = nz;
        ax_inv = cfg.inv_z;
      end
    endcase
  end

  always_comb begin
    fold_h   = ACC_W'(ax_n) << (FB2 - 1);
    fold_t   = mac_res;
    fold_oor = 1'b0;
    case (axis_r)
      AXIS_X: begin
        if (!neg_r[AXIS_X]) begin
          fold_t = mac_res + fold_h;
        end else if (mac_res > fold_h) begin
          fold_t   = '0;
          fold_oor = 1'b1;
        end else begin
          fold_t = fold_h - mac_res;
        end
      end
      AXIS_Y: begin
        if (neg_r[AXIS_Y]) begin
          fold_t = mac_res + fold_h;
        end else if (mac_res >= fold_h) begin
          fold_t = mac_res - fold_h;
        end else begin
          fold_t = fold_h - mac_res;
        end
      end
      default: fold_t = mac_res;
    endcase
  end

  always_comb begin
    xs[0]   = coord_r[0];
    xs[1]   = wrap_inc(coord_r[0], nx);
    xs[2]   = wrap_dec(coord_r[0], nx);
    ys[0]   = coord_r[1];
    ys[1]   = wrap_inc(coord_r[1], ny);
    ys[2]   = wrap_dec(coord_r[1], ny);
    has_m   = cfg.z_periodic || (coord_r[2] != '0);
    has_p   = cfg.z_periodic || ((CW'(coord_r[2]) + CW'(1)) < nz);
    zs[0]   = coord_r[2];
    zs[1]   = has_m ? wrap_dec(coord_r[2], nz) : wrap_inc(coord_r[2], nz);
    zs[2]   = wrap_inc(coord_r[2], nz);
    nplanes = 2'd1 + 2'(has_m) + 2'(has_p);
  end

  assign emit_idx  = IDX_W'(xs[i_r]) + rowoff_r[j_r] + planeoff_r[p_r];
  assign emit_last = (p_r == (nplanes - 2'd1)) && (i_r == LAST_TAP) && (j_r == LAST_TAP);

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    op_nxt        = op_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    ncrd_nxt      = ncrd_r;
    coord_nxt     = coord_r;
    oor_nxt       = oor_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    nxny_nxt      = nxny_r;
    rowoff_nxt    = rowoff_r;
    planeoff_nxt  = planeoff_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_oor_nxt   = out_oor_r;
    out_last_nxt  = out_last_r;
    mac_cmd       = '0;
    rem_start     = 1'b0;
    rem_dividend  = '0;
    rem_divisor   = ax_n;
    rem_steps     = STW'(NSTEPS);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_opcode;
          mag_nxt[0]  = mag33(in_vx);
          mag_nxt[1]  = mag33(in_vy);
          mag_nxt[2]  = mag33(in_vz);
          neg_nxt[0]  = in_vx[MAC_A_W-1];
          neg_nxt[1]  = in_vy[MAC_A_W-1];
          neg_nxt[2]  = in_vz[MAC_A_W-1];
          ncrd_nxt[0] = in_cell_col;
          ncrd_nxt[1] = in_cell_row;
          ncrd_nxt[2] = in_cell_layer;
          axis_nxt    = AXIS_X;
          oor_nxt     = 1'b0;
          state_nxt   = (in_opcode == OP_BIN) ? S_MLO : S_NSTART;
        end
      end
      S_MLO: begin
        mac_cmd.en = 1'b1;
        mac_cmd.a  = mag_r[axis_r];
        mac_cmd.b  = ax_inv[MAC_B_W-1:0];
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        mac_cmd.en     = 1'b1;
        mac_cmd.sh     = 1'b1;
        mac_cmd.a      = mag_r[axis_r];
        mac_cmd.b      = ax_inv[POS_W-1:MAC_B_W];
        mac_cmd.addend = mac_res;
        state_nxt      = S_FOLD;
      end
      S_FOLD: begin
        rem_start    = 1'b1;
        rem_dividend = QP'(fold_t >> FB2);
        if (axis_r == AXIS_X) begin
          oor_nxt = fold_oor;
        end
        state_nxt = S_RWAIT;
      end
      S_NSTART: begin
        rem_start    = 1'b1;
        rem_dividend = QP'(ncrd_r[axis_r]) << (QP - NBR_PAD);
        rem_steps    = STW'(NBR_STEPS);
        state_nxt    = S_RWAIT;
      end
      S_RWAIT: begin
        if (!rem_busy) begin
          coord_nxt[axis_r] = rem_val[CRW-1:0];
          if (axis_r == AXIS_Z) begin
            k_nxt     = '0;
            state_nxt = (op_r == OP_BIN) ? S_IDX1 : S_OFF;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = (op_r == OP_BIN) ? S_MLO : S_NSTART;
          end
        end
      end
      S_IDX1: begin
        mac_cmd.en     = 1'b1;
        mac_cmd.a      = MAC_A_W'(coord_r[2]);
        mac_cmd.b      = MAC_B_W'(ny);
        mac_cmd.addend = ACC_W'(coord_r[1]);
        state_nxt      = S_IDX2;
      end
      S_IDX2: begin
        mac_cmd.en     = 1'b1;
        mac_cmd.a      = MAC_A_W'(mac_res[IDX_W-1:0]);
        mac_cmd.b      = MAC_B_W'(nx);
        mac_cmd.addend = ACC_W'(coord_r[0]);
        state_nxt      = S_EMIT;
      end
      S_OFF: begin
        mac_cmd.en = (k_r != OFF_LAST);
        case (k_r) inside
          3'd0: begin
            mac_cmd.a = MAC_A_W'(nx);
            mac_cmd.b = MAC_B_W'(ny);
          end
          3'd1, 3'd2, 3'd3: begin
            mac_cmd.a = MAC_A_W'(ys[2'(k_r - 3'd1)]);
            mac_cmd.b = MAC_B_W'(nx);
          end
          3'd4, 3'd5, 3'd6: begin
            mac_cmd.a = MAC_A_W'(nxny_r);
            mac_cmd.b = MAC_B_W'(zs[2'(k_r - 3'd4)]);
          end
          default: ;
        endcase
        case (k_r) inside
          3'd1:             nxny_nxt = mac_res[IDX_W-1:0];
          3'd2, 3'd3, 3'd4: rowoff_nxt[2'(k_r - 3'd2)] = mac_res[IDX_W-1:0];
          3'd5, 3'd6, 3'd7: planeoff_nxt[2'(k_r - 3'd5)] = mac_res[IDX_W-1:0];
          default: ;
        endcase
        if (k_r == OFF_LAST) begin
          i_nxt     = '0;
          j_nxt     = '0;
          p_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (op_r == OP_BIN) begin
            out_idx_nxt  = mac_res[IDX_W-1:0];
            out_oor_nxt  = oor_r;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            out_idx_nxt  = emit_idx;
            out_oor_nxt  = 1'b0;
            out_last_nxt = emit_last;
            if (emit_last) begin
              state_nxt = S_IDLE;
            end
            if (j_r == LAST_TAP) begin
              j_nxt = '0;
              if (i_r == LAST_TAP) begin
                i_nxt = '0;
                p_nxt = p_r + 2'd1;
              end else begin
                i_nxt = i_r + 2'd1;
              end
            end else begin
              j_nxt = j_r + 2'd1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_X;
      op_r        <= OP_BIN;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      p_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      op_r        <= op_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      p_r         <= p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    ncrd_r     <= ncrd_nxt;
    coord_r    <= coord_nxt;
    oor_r      <= oor_nxt;
    nxny_r     <= nxny_nxt;
    rowoff_r   <= rowoff_nxt;
    planeoff_r <= planeoff_nxt;
    out_idx_r  <= out_idx_nxt;
    out_oor_r  <= out_oor_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef NO_ASSERTIONS
  a_oor_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_last)
    else $error("out of range flag on a word that is not last");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after an accepted word");

  a_rem_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !rem_busy)
    else $error("remainder unit busy while sequencer idle");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && out_valid_r && !out_ready |=> state_r == S_EMIT)
    else $error("sequencer left emit while output slot blocked");
`endif

endmodule
